/* rtl/ppdac_pkg.sv */
package ppdac_pkg;

    localparam int DATA_W         = 8;
    localparam int OPCODE_W       = 3;
    localparam int MONO_CNT_W     = 3;
    localparam int FIFO_DEPTH_DEF = 16;

    typedef logic [DATA_W-1:0]     byte_t;
    typedef logic [OPCODE_W-1:0]   opcode_t;
    typedef logic [MONO_CNT_W-1:0] mono_cnt_t;

    localparam opcode_t OP_DATA_WR = 3'd0;
    localparam opcode_t OP_CTRL_WR = 3'd1;
    localparam opcode_t OP_CTRL_RD = 3'd2;
    localparam opcode_t OP_STAT_RD = 3'd3;
    localparam opcode_t OP_TICK    = 3'd4;

    localparam byte_t IDLE_LEVEL  = 8'h80;
    localparam byte_t STATUS_BASE = 8'h03;
    localparam byte_t STATUS_FULL = 8'h40;

    localparam mono_cnt_t MONO_LIMIT = 3'd5;
    localparam mono_cnt_t MONO_HOLD  = 3'd4;

    // control byte bit positions
    localparam int CTRL_LEFT  = 0;
    localparam int CTRL_RIGHT = 1;
    localparam int CTRL_POWER = 2;
    localparam int CTRL_PUSH  = 3;

endpackage

/* rtl/ppdac_in_if.sv */
interface ppdac_in_if;
    import ppdac_pkg::*;

    logic    valid;
    logic    ready;
    opcode_t opcode;
    byte_t   write_byte;

    modport source (output valid, output opcode, output write_byte, input ready);
    modport sink   (input valid, input opcode, input write_byte, output ready);
endinterface

/* rtl/ppdac_out_if.sv */
interface ppdac_out_if;
    import ppdac_pkg::*;

    logic  valid;
    logic  ready;
    byte_t read_byte;
    logic  sample_valid;
    byte_t sample_out;
    byte_t left_level;
    byte_t right_level;
    logic  irq;

    modport source (
        output valid, output read_byte, output sample_valid, output sample_out,
        output left_level, output right_level, output irq, input ready
    );
    modport sink (
        input valid, input read_byte, input sample_valid, input sample_out,
        input left_level, input right_level, input irq, output ready
    );
endinterface

/* rtl/ppdac_fifo.sv */
module ppdac_fifo #(
    parameter int DEPTH = ppdac_pkg::FIFO_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [ppdac_pkg::DATA_W-1:0] push_data,
    input  logic                     pop,
    output logic                     empty,
    output logic                     full,
    output logic [ppdac_pkg::DATA_W-1:0] pop_data
);
    import ppdac_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    byte_t         mem [DEPTH];
    byte_t         pop_data_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push_ok;
    logic          pop_ok;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign push_ok  = push && !full;
    assign pop_ok   = pop && !empty;
    assign pop_data = pop_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push_ok)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        end
        if (pop_ok)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // registered read port; holds while no pop so a stalled beat keeps its sample
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail_reg] <= push_data;
        end
        if (pop_ok)
        begin
            pop_data_reg <= mem[head_reg];
        end
    end

endmodule

/* rtl/parallel_port_dac_fifo_unit.sv */
// Channel  Dir  Role    Payload
// in_ch    in   sink    opcode[2:0], write_byte[7:0]
// out_ch   out  source  read_byte, sample_valid, sample_out, left_level, right_level, irq
//
// One beat per cycle; each input beat gives one output beat on the next cycle.
// All state updates but out_valid happen at the accepting edge; the sample FIFO read is
// registered in the same edge, so sample_out is valid with the output beat.
// in_ch.ready drops only while an output beat is held and out_ch.ready is low.
// Reset initialises all control state (levels to IDLE_LEVEL); FIFO contents are not cleared.
module parallel_port_dac_fifo_unit #(
    parameter int FIFO_DEPTH = ppdac_pkg::FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ppdac_in_if.sink    in_ch,
    ppdac_out_if.source out_ch
);
    import ppdac_pkg::*;

    byte_t     data_latch_reg, data_latch_next;
    byte_t     last_control_reg, last_control_next;
    byte_t     left_reg, left_next;
    byte_t     right_reg, right_next;
    logic      mono_mode_reg, mono_mode_next;
    mono_cnt_t mono_count_reg, mono_count_next;
    logic      full_flag_reg, full_flag_next;
    logic      out_valid_reg, out_valid_next;
    byte_t     read_byte_reg, read_byte_next;
    logic      sample_valid_reg, sample_valid_next;

    logic      accept;
    byte_t     falling;
    mono_cnt_t mono_inc;
    logic      edge_hit;
    logic      push;
    logic      pop;
    logic      fifo_empty;
    logic      fifo_full;
    byte_t     pop_data;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign falling     = last_control_reg & ~in_ch.write_byte;
    assign mono_inc    = mono_count_reg + 1'b1;

    always_comb
    begin
        data_latch_next   = data_latch_reg;
        last_control_next = last_control_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        mono_mode_next    = mono_mode_reg;
        mono_count_next   = mono_count_reg;
        full_flag_next    = full_flag_reg;
        read_byte_next    = read_byte_reg;
        sample_valid_next = sample_valid_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        edge_hit          = 1'b0;
        push              = 1'b0;
        pop               = 1'b0;

        if (accept)
        begin
            out_valid_next    = 1'b1;
            read_byte_next    = '0;
            sample_valid_next = 1'b0;
            case (in_ch.opcode)
                OP_DATA_WR:
                begin
                    data_latch_next = in_ch.write_byte;
                    if (mono_mode_reg)
                    begin
                        left_next  = in_ch.write_byte;
                        right_next = in_ch.write_byte;
                    end
                    else if (mono_inc == MONO_LIMIT)
                    begin
                        mono_mode_next  = 1'b1;
                        mono_count_next = MONO_HOLD;
                    end
                    else
                    begin
                        mono_count_next = mono_inc;
                    end
                end
                OP_CTRL_WR:
                begin
                    // push is dropped by the FIFO when full; the edge still counts
                    if (in_ch.write_byte[CTRL_POWER] && falling[CTRL_PUSH])
                    begin
                        push     = 1'b1;
                        edge_hit = 1'b1;
                    end
                    if (falling[CTRL_LEFT])
                    begin
                        left_next = data_latch_reg;
                        edge_hit  = 1'b1;
                    end
                    if (falling[CTRL_RIGHT])
                    begin
                        right_next = data_latch_reg;
                        edge_hit   = 1'b1;
                    end
                    if (edge_hit)
                    begin
                        mono_mode_next  = 1'b0;
                        mono_count_next = '0;
                    end
                    last_control_next = in_ch.write_byte;
                end
                OP_CTRL_RD:
                begin
                    read_byte_next = last_control_reg;
                end
                OP_STAT_RD:
                begin
                    read_byte_next = STATUS_BASE
                                   | {~data_latch_reg[DATA_W-1], {(DATA_W-1){1'b0}}}
                                   | (full_flag_reg ? STATUS_FULL : '0);
                end
                OP_TICK:
                begin
                    full_flag_next = fifo_full;
                    if (last_control_reg[CTRL_POWER] && !fifo_empty)
                    begin
                        pop               = 1'b1;
                        sample_valid_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_latch_reg   <= '0;
            last_control_reg <= '0;
            left_reg         <= IDLE_LEVEL;
            right_reg        <= IDLE_LEVEL;
            mono_mode_reg    <= 1'b0;
            mono_count_reg   <= '0;
            full_flag_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            read_byte_reg    <= '0;
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            data_latch_reg   <= data_latch_next;
            last_control_reg <= last_control_next;
            left_reg         <= left_next;
            right_reg        <= right_next;
            mono_mode_reg    <= mono_mode_next;
            mono_count_reg   <= mono_count_next;
            full_flag_reg    <= full_flag_next;
            out_valid_reg    <= out_valid_next;
            read_byte_reg    <= read_byte_next;
            sample_valid_reg <= sample_valid_next;
        end
    end

    ppdac_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (data_latch_reg),
        .pop       (pop),
        .empty     (fifo_empty),
        .full      (fifo_full),
        .pop_data  (pop_data)
    );

    // state other than out_valid only moves on an accepted beat, so the live levels belong to the held beat
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.read_byte    = read_byte_reg;
    assign out_ch.sample_valid = sample_valid_reg;
    assign out_ch.sample_out   = sample_valid_reg ? pop_data : IDLE_LEVEL;
    assign out_ch.left_level   = left_reg;
    assign out_ch.right_level  = right_reg;
    assign out_ch.irq          = full_flag_reg;

endmodule

/* rtl/ppdac_checker.sv */
module ppdac_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [ppdac_pkg::OPCODE_W-1:0]   in_opcode,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [ppdac_pkg::DATA_W-1:0]     out_read_byte,
    input logic                             out_sample_valid,
    input logic [ppdac_pkg::DATA_W-1:0]     out_sample_out,
    input logic                             out_irq
);
    import ppdac_pkg::*;

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid)
        else $error("accepted beat gave no output beat");

    a_idle_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_sample_valid |-> out_sample_out == IDLE_LEVEL)
        else $error("sample_out not idle level without a pop");

    a_status_bits: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_opcode == OP_STAT_RD |=> out_read_byte[1:0] == 2'b11)
        else $error("status byte missing fixed bits");

    a_irq_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_acc && in_opcode == OP_TICK) |=> $stable(out_irq))
        else $error("irq moved without a tick");

endmodule

bind parallel_port_dac_fifo_unit ppdac_checker u_ppdac_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_opcode        (in_ch.opcode),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_read_byte    (out_ch.read_byte),
    .out_sample_valid (out_ch.sample_valid),
    .out_sample_out   (out_ch.sample_out),
    .out_irq          (out_ch.irq)
);
